// ===== hdl/aea_pkg.sv =====
// Shared types, constants and the exponential table of the auto exposure adaptation block.
package aea_pkg;

   // Configuration port geometry: eight 32-bit registers at byte addresses 4*i.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [2:0] REG_KEY_LOG    = 3'd0;
   localparam logic [2:0] REG_EXP_OFFSET = 3'd1;
   localparam logic [2:0] REG_WHITE_LOG  = 3'd2;
   localparam logic [2:0] REG_EV_LOWEST  = 3'd3;
   localparam logic [2:0] REG_EV_HIGHEST = 3'd4;
   localparam logic [2:0] REG_DEADBAND   = 3'd5;
   localparam logic [2:0] REG_TAU_RISE   = 3'd6;
   localparam logic [2:0] REG_TAU_FALL   = 3'd7;

   // Fixed tuning constants: key pull for negative steps (Q16) and frame time limits.
   localparam logic [16:0] KEY_PULL_Q16 = 17'd32768;
   localparam logic [15:0] DT_LOWEST    = 16'd0;
   localparam logic [15:0] DT_HIGHEST   = 16'd256;

   // One in Q30 and the sequencing limits.
   localparam logic [30:0] E_ONE    = 31'h4000_0000;
   localparam logic [4:0]  DIV_LAST = 5'd31;
   localparam logic [4:0]  EXP_LAST = 5'd19;

   typedef struct packed {
      logic signed [15:0] key_log;
      logic signed [15:0] exposure_offset;
      logic signed [15:0] white_log;
      logic signed [15:0] ev_lowest;
      logic signed [15:0] ev_highest;
      logic        [14:0] deadband;
      logic        [15:0] tau_rise;
      logic        [15:0] tau_fall;
   } aea_cfg_type;

   typedef struct packed {
      logic signed [15:0] median_log;
      logic signed [15:0] peak_log;
      logic               neutral;
      logic        [15:0] frame_time;
   } aea_req_type;

   typedef struct packed {
      logic signed [15:0] adapted_ev;
      logic signed [15:0] ev_held_target;
      logic signed [15:0] ev_key_out;
      logic signed [15:0] ev_limit_out;
   } aea_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       ready;
      logic       load;
      logic       key;
      logic       lim;
      logic       fresh;
      logic       prep;
      logic       div;
      logic       exp;
      logic       rate;
      logic       fin;
      logic       emit;
      logic [4:0] idx;
   } aea_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic tau_zero;
      logic x_big;
   } aea_stat_type;

   // Saturate an 18-bit signed value to the 16-bit signed range.
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v < -18'sd32768) begin
         r = -16'sd32768;
      end else if (v > 18'sd32767) begin
         r = 16'sd32767;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // round(2^30 * exp(-2^(k-16))) for bit k of the Q16 exponent.
   function automatic logic [29:0] exp_rom(input logic [4:0] k);
      logic [29:0] r;
      case (k)
         5'd0:    r = 30'd1073725440;
         5'd1:    r = 30'd1073709056;
         5'd2:    r = 30'd1073676290;
         5'd3:    r = 30'd1073610760;
         5'd4:    r = 30'd1073479712;
         5'd5:    r = 30'd1073217664;
         5'd6:    r = 30'd1072693760;
         5'd7:    r = 30'd1071646719;
         5'd8:    r = 30'd1069555701;
         5'd9:    r = 30'd1065385899;
         5'd10:   r = 30'd1057095000;
         5'd11:   r = 30'd1040706261;
         5'd12:   r = 30'd1008687096;
         5'd13:   r = 30'd947573834;
         5'd14:   r = 30'd836230973;
         5'd15:   r = 30'd651257337;
         5'd16:   r = 30'd395007542;
         5'd17:   r = 30'd145315154;
         5'd18:   r = 30'd19666268;
         5'd19:   r = 30'd360200;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/aea_ctrl.sv =====
// Controller state machine that sequences one frame update through the datapath.
module aea_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   input  aea_pkg::aea_stat_type status,
   output aea_pkg::aea_cmd_type  cmd
);
   import aea_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_KEY, S_LIM, S_FRESH, S_PREP, S_DIV, S_EXP, S_RATE, S_FIN, S_DONE
   } state_type;

   state_type  state_ff;
   logic [4:0] cnt_ff;

   // Decode the current step into datapath commands.
   always_comb begin
      cmd       = '0;
      cmd.ready = (state_ff == S_IDLE);
      cmd.load  = (state_ff == S_IDLE) && req_valid;
      cmd.key   = (state_ff == S_KEY);
      cmd.lim   = (state_ff == S_LIM);
      cmd.fresh = (state_ff == S_FRESH);
      cmd.prep  = (state_ff == S_PREP);
      cmd.div   = (state_ff == S_DIV) && !status.tau_zero;
      cmd.exp   = (state_ff == S_EXP) && !status.x_big;
      cmd.rate  = (state_ff == S_RATE);
      cmd.fin   = (state_ff == S_FIN);
      cmd.emit  = (state_ff == S_DONE) && out_free;
      cmd.idx   = cnt_ff;
   end

   // State and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_KEY;
               end
            end
            S_KEY:   state_ff <= S_LIM;
            S_LIM:   state_ff <= S_FRESH;
            S_FRESH: state_ff <= S_PREP;
            S_PREP: begin
               state_ff <= S_DIV;
               cnt_ff   <= '0;
            end
            S_DIV: begin
               // A zero time constant needs neither the quotient nor the exponential.
               if (status.tau_zero) begin
                  state_ff <= S_RATE;
               end else if (cnt_ff == DIV_LAST) begin
                  state_ff <= S_EXP;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_EXP: begin
               if (status.x_big || (cnt_ff == EXP_LAST)) begin
                  state_ff <= S_RATE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_RATE: state_ff <= S_FIN;
            S_FIN:  state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // An accepted item always starts with the key step.
   a_load_to_key: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_KEY)
      else $error("accepted item did not start the key step");

   // The exponential walk never runs past the last table entry.
   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXP |-> cnt_ff <= EXP_LAST)
      else $error("exponential step index out of range");

   // Handing a result to the output register frees the block for the next item.
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("controller did not return to idle after a result");

endmodule

// ===== hdl/aea_dp.sv =====
// Datapath: key and limit exposure, deadband, restoring divider and exponential rate.
module aea_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  aea_pkg::aea_cfg_type  cfg,
   input  aea_pkg::aea_req_type  req_data,
   input  aea_pkg::aea_cmd_type  cmd,
   output aea_pkg::aea_stat_type status,
   output aea_pkg::aea_rsp_type  result
);
   import aea_pkg::*;

   // Captured item fields.
   logic signed [15:0] median_ff, median_in;
   logic signed [15:0] peak_ff, peak_in;
   logic               neutral_ff, neutral_in;
   logic        [15:0] dt_ff, dt_in;

   // Key step registers.
   logic signed [16:0] kdiff_ff, kdiff_in;
   logic               key_neg_ff, key_neg_in;
   logic        [32:0] kprod_ff, kprod_in;
   logic signed [15:0] ev_key_ff, ev_key_in;
   logic signed [15:0] ev_lim_ff, ev_lim_in;

   // Frame state.
   logic signed [15:0] held_ff, held_in;
   logic signed [15:0] adapted_ff, adapted_in;
   logic               first_ff, first_in;

   // Adaptation registers.
   logic        [15:0] tau_ff, tau_in;
   logic               tau_zero_ff, tau_zero_in;
   logic        [15:0] dmag_ff, dmag_in;
   logic               delta_neg_ff, delta_neg_in;
   logic        [31:0] num_ff, num_in;
   logic        [15:0] rem_ff, rem_in;
   logic        [30:0] e_ff, e_in;
   logic        [46:0] sprod_ff, sprod_in;

   // Combinational intermediates.
   logic signed [15:0] ev_lo, ev_hi, offset;
   logic signed [16:0] key_diff, lim_diff, held_diff, adapt_delta;
   logic        [15:0] key_mag;
   logic        [32:0] key_rnd;
   logic signed [17:0] key_step, key_sum;
   logic signed [15:0] ev_min, fresh;
   logic        [16:0] held_mag;
   logic        [15:0] dt_clamp, tau_sel;
   logic        [16:0] div_trial;
   logic               div_ge;
   logic        [29:0] rom_val;
   logic        [60:0] exp_prod, exp_rnd;
   logic               rate_full;
   logic        [30:0] rate;
   logic        [46:0] step_rnd;
   logic        [16:0] step_mag;
   logic signed [17:0] step_s, adapt_sum, lo18, hi18;
   logic signed [15:0] adapt_new;

   assign ev_lo  = cfg.ev_lowest;
   assign ev_hi  = cfg.ev_highest;
   assign offset = cfg.exposure_offset;

   // Key difference and its pulled magnitude product for negative steps.
   always_comb begin
      key_diff = {cfg.key_log[15], cfg.key_log} - {median_ff[15], median_ff};
      key_mag  = 16'(-key_diff);
   end

   // Rounded key step, offset, saturation, and the highlight limit.
   always_comb begin
      key_rnd  = kprod_ff + 33'd32768;
      key_step = key_neg_ff ? -$signed({1'b0, key_rnd[32:16]}) : {kdiff_ff[16], kdiff_ff};
      key_sum  = key_step + {{2{offset[15]}}, offset};
      lim_diff = {cfg.white_log[15], cfg.white_log} - {peak_ff[15], peak_ff};
   end

   // New target: lower of key and limit, clamped; then the deadband test.
   always_comb begin
      ev_min = (ev_key_ff < ev_lim_ff) ? ev_key_ff : ev_lim_ff;
      if (ev_min < ev_lo) begin
         fresh = ev_lo;
      end else if (ev_min > ev_hi) begin
         fresh = ev_hi;
      end else begin
         fresh = ev_min;
      end
      held_diff = {fresh[15], fresh} - {held_ff[15], held_ff};
      held_mag  = held_diff[16] ? 17'(-held_diff) : 17'(held_diff);
   end

   // Frame time clamp, time constant choice and adaptation delta.
   always_comb begin
      if (dt_ff < DT_LOWEST) begin
         dt_clamp = DT_LOWEST;
      end else if (dt_ff > DT_HIGHEST) begin
         dt_clamp = DT_HIGHEST;
      end else begin
         dt_clamp = dt_ff;
      end
      tau_sel     = (held_ff < adapted_ff) ? cfg.tau_fall : cfg.tau_rise;
      adapt_delta = {held_ff[15], held_ff} - {adapted_ff[15], adapted_ff};
   end

   // One restoring division step and one exponential product a cycle.
   always_comb begin
      div_trial = {rem_ff, num_ff[31]};
      div_ge    = div_trial >= {1'b0, tau_ff};
      rom_val   = exp_rom(cmd.idx);
      exp_prod  = {30'd0, e_ff} * {31'd0, rom_val};
      exp_rnd   = exp_prod + 61'h2000_0000;
   end

   // Rate and the final rounded, clamped move toward the target.
   always_comb begin
      rate_full = tau_zero_ff | (|num_ff[31:20]);
      rate      = rate_full ? E_ONE : (E_ONE - e_ff);
      step_rnd  = sprod_ff + 47'h2000_0000;
      step_mag  = step_rnd[46:30];
      step_s    = delta_neg_ff ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      adapt_sum = {{2{adapted_ff[15]}}, adapted_ff} + step_s;
      lo18      = {{2{ev_lo[15]}}, ev_lo};
      hi18      = {{2{ev_hi[15]}}, ev_hi};
      if (adapt_sum < lo18) begin
         adapt_new = ev_lo;
      end else if (adapt_sum > hi18) begin
         adapt_new = ev_hi;
      end else begin
         adapt_new = adapt_sum[15:0];
      end
   end

   // Next values under the controller's commands.
   always_comb begin
      median_in    = median_ff;
      peak_in      = peak_ff;
      neutral_in   = neutral_ff;
      dt_in        = dt_ff;
      kdiff_in     = kdiff_ff;
      key_neg_in   = key_neg_ff;
      kprod_in     = kprod_ff;
      ev_key_in    = ev_key_ff;
      ev_lim_in    = ev_lim_ff;
      held_in      = held_ff;
      adapted_in   = adapted_ff;
      first_in     = first_ff;
      tau_in       = tau_ff;
      tau_zero_in  = tau_zero_ff;
      dmag_in      = dmag_ff;
      delta_neg_in = delta_neg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      e_in         = e_ff;
      sprod_in     = sprod_ff;
      if (cmd.load) begin
         median_in  = req_data.median_log;
         peak_in    = req_data.peak_log;
         neutral_in = req_data.neutral;
         dt_in      = req_data.frame_time;
      end
      if (cmd.key) begin
         kdiff_in   = key_diff;
         key_neg_in = key_diff[16];
         kprod_in   = {17'd0, key_mag} * {16'd0, KEY_PULL_Q16};
      end
      if (cmd.lim) begin
         ev_key_in = neutral_ff ? offset : sat16(key_sum);
         ev_lim_in = sat16({lim_diff[16], lim_diff});
      end
      if (cmd.fresh) begin
         if (first_ff || (held_mag > {2'b00, cfg.deadband})) begin
            held_in = fresh;
         end
         first_in = 1'b0;
      end
      if (cmd.prep) begin
         tau_in       = tau_sel;
         tau_zero_in  = (tau_sel == 16'd0);
         dmag_in      = 16'(adapt_delta[16] ? -adapt_delta : adapt_delta);
         delta_neg_in = adapt_delta[16];
         num_in       = {dt_clamp, 16'd0};
         rem_in       = '0;
         e_in         = E_ONE;
      end
      if (cmd.div) begin
         rem_in = div_ge ? 16'(div_trial - {1'b0, tau_ff}) : div_trial[15:0];
         num_in = {num_ff[30:0], div_ge};
      end
      if (cmd.exp && num_ff[cmd.idx]) begin
         e_in = exp_rnd[60:30];
      end
      if (cmd.rate) begin
         sprod_in = {31'd0, dmag_ff} * {16'd0, rate};
      end
      if (cmd.fin) begin
         adapted_in = adapt_new;
      end
   end

   // Frame state that reset defines.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         adapted_ff <= '0;
         first_ff   <= 1'b1;
      end else begin
         held_ff    <= held_in;
         adapted_ff <= adapted_in;
         first_ff   <= first_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      median_ff    <= median_in;
      peak_ff      <= peak_in;
      neutral_ff   <= neutral_in;
      dt_ff        <= dt_in;
      kdiff_ff     <= kdiff_in;
      key_neg_ff   <= key_neg_in;
      kprod_ff     <= kprod_in;
      ev_key_ff    <= ev_key_in;
      ev_lim_ff    <= ev_lim_in;
      tau_ff       <= tau_in;
      tau_zero_ff  <= tau_zero_in;
      dmag_ff      <= dmag_in;
      delta_neg_ff <= delta_neg_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      e_ff         <= e_in;
      sprod_ff     <= sprod_in;
   end

   assign status.tau_zero = tau_zero_ff;
   assign status.x_big    = |num_ff[31:20];

   assign result.adapted_ev     = adapted_ff;
   assign result.ev_held_target = held_ff;
   assign result.ev_key_out     = ev_key_ff;
   assign result.ev_limit_out   = ev_lim_ff;

   // The partial remainder stays below the divisor throughout the division.
   a_rem_below_tau: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> rem_ff < tau_ff)
      else $error("divider remainder reached the divisor");

   // The first frame always takes the new target.
   a_first_takes: assert property (@(posedge clock) disable iff (reset)
      cmd.fresh && first_ff |=> held_ff == $past(fresh))
      else $error("first frame did not take the new target");

   // With an ordered EV range the adapted value lands inside it.
   a_adapted_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> ($past(ev_lo) > $past(ev_hi)) ||
                  ((adapted_ff >= $past(ev_lo)) && (adapted_ff <= $past(ev_hi))))
      else $error("adapted value outside the EV range");

endmodule

// ===== hdl/auto_exposure_adapt_core.sv =====
// Top level of the auto exposure adaptation block: register file, output register, core.
//
// One item per frame: median and 99th-percentile peak log luminance, a neutral flag and
// the frame time. Each item yields exactly one result with the adapted EV, the held
// target after the deadband, the key exposure and the highlight limit, all Q5.10 EV.
// From acceptance to a result in the output register an item passes through seven fixed
// steps, a one-bit-per-cycle restoring divider of 32 steps that forms frame_time / tau,
// and 20 steps of a shared 31x30 multiplier that builds exp(-x) one exponent bit at a
// time. A zero time constant skips the divider and the exponential; a frame of 16 or
// more time constants cuts the exponential to a single step. A stalled output register
// keeps the finished result waiting in the block until the register frees. A new item
// is taken once the previous result sits in the output register, even while that result
// is still stalled. The user must see that registers are written through the APB-style
// port only while no item is in flight; the block itself does not enforce this.
module auto_exposure_adapt_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input item channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  aea_pkg::aea_req_type                req_data,
   // Result item channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output aea_pkg::aea_rsp_type                rsp_data,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [aea_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [aea_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [aea_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import aea_pkg::*;

   aea_cfg_type  cfg_ff, cfg_in;
   aea_cmd_type  cmd;
   aea_stat_type status;
   aea_rsp_type  result;
   aea_rsp_type  rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         csr_wr;
   logic [2:0]   csr_idx;
   logic         out_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_KEY_LOG:    cfg_in.key_log         = csr_pwdata[15:0];
            REG_EXP_OFFSET: cfg_in.exposure_offset = csr_pwdata[15:0];
            REG_WHITE_LOG:  cfg_in.white_log       = csr_pwdata[15:0];
            REG_EV_LOWEST:  cfg_in.ev_lowest       = csr_pwdata[15:0];
            REG_EV_HIGHEST: cfg_in.ev_highest      = csr_pwdata[15:0];
            REG_DEADBAND:   cfg_in.deadband        = csr_pwdata[14:0];
            REG_TAU_RISE:   cfg_in.tau_rise        = csr_pwdata[15:0];
            REG_TAU_FALL:   cfg_in.tau_fall        = csr_pwdata[15:0];
            default:        cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_log         <= 16'sd0;
         cfg_ff.exposure_offset <= 16'sd0;
         cfg_ff.white_log       <= 16'sd0;
         cfg_ff.ev_lowest       <= -16'sd8192;
         cfg_ff.ev_highest      <= 16'sd8192;
         cfg_ff.deadband        <= 15'd0;
         cfg_ff.tau_rise        <= 16'd1024;
         cfg_ff.tau_fall        <= 16'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads.
   always_comb begin
      case (csr_idx)
         REG_KEY_LOG:    csr_prdata = {16'd0, cfg_ff.key_log};
         REG_EXP_OFFSET: csr_prdata = {16'd0, cfg_ff.exposure_offset};
         REG_WHITE_LOG:  csr_prdata = {16'd0, cfg_ff.white_log};
         REG_EV_LOWEST:  csr_prdata = {16'd0, cfg_ff.ev_lowest};
         REG_EV_HIGHEST: csr_prdata = {16'd0, cfg_ff.ev_highest};
         REG_DEADBAND:   csr_prdata = {17'd0, cfg_ff.deadband};
         REG_TAU_RISE:   csr_prdata = {16'd0, cfg_ff.tau_rise};
         REG_TAU_FALL:   csr_prdata = {16'd0, cfg_ff.tau_fall};
         default:        csr_prdata = '0;
      endcase
   end

   // Input handshake: items are taken only when the sequencer is idle.
   assign req_stall = !cmd.ready;

   // Output register: loaded when it is empty or its item leaves in the same cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   aea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   aea_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .result   (result)
   );

endmodule
